/* rtl/rgbsf_pkg.sv */
// shared types and constants of the rgb three-tap smoothing filter
package rgbsf_pkg;

  localparam int unsigned CH_W      = 8;
  localparam int unsigned NUM_CH    = 3;
  localparam int unsigned COL_W     = 11;
  localparam int unsigned ROW_W     = 11;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 12;
  localparam int unsigned STR_W     = 8;
  localparam int unsigned DIM_W     = 12;
  localparam int unsigned DIV_STEPS = 8;
  localparam int unsigned MIN_DIM   = 3;

  localparam logic [STR_W-1:0] STRENGTH_RST = 8'd1;
  localparam logic [DIM_W-1:0] WIDTH_RST    = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST   = 12'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STRENGTH  = 4'd0,
    CFG_WIDTH     = 4'd1,
    CFG_HEIGHT    = 4'd2,
    CFG_DIRECTION = 4'd3
  } cfg_idx_e;

  typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;

  typedef struct packed {
    logic [STR_W-1:0] strength;
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic             direction;
  } cfg_t;

  typedef struct packed {
    pix_t p0;
    pix_t p1;
    pix_t p2;
    logic dir;
    logic three;
  } job_t;

endpackage

/* rtl/rgbsf_if.sv */
// stream and configuration interfaces of the smoothing filter
interface rgbsf_pix_if;
  import rgbsf_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] in_red;
  logic [CH_W-1:0] in_green;
  logic [CH_W-1:0] in_blue;
  modport source (output valid, in_red, in_green, in_blue, input ready);
  modport sink (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface rgbsf_res_if;
  import rgbsf_pkg::*;
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  out_red;
  logic [CH_W-1:0]  out_green;
  logic [CH_W-1:0]  out_blue;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic             last_of_run;
  modport source (output valid, out_red, out_green, out_blue, out_col, out_row, last_of_run,
                  input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_col, out_row, last_of_run,
                output ready);
endinterface

interface rgbsf_cfg_if;
  import rgbsf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/rgbsf_ram.sv */
// generic single-write single-read ram with registered read data
module rgbsf_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/rgbsf_front.sv */
// front end: pixel intake, frame position, line stores and job forming
module rgbsf_front import rgbsf_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  rgbsf_pix_if.sink                     pix_i,
  output logic                          push_o,
  output job_t                          job_o,
  output logic [$clog2(MAX_WIDTH)-1:0]  col_o,
  output logic [$clog2(MAX_HEIGHT)-1:0] row_o,
  input  logic                          full_i
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned WWN = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HWN = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned WW  = (WWN > DIM_W) ? WWN : DIM_W;
  localparam int unsigned HW  = (HWN > DIM_W) ? HWN : DIM_W;

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_LOOK = 2'b10
  } fstate_e;

  fstate_e state_q, state_d;

  pix_t          older_pix_q, newer_pix_q;
  logic [CW-1:0] col_cnt_q;
  logic [RW-1:0] row_cnt_q;

  pix_t          cur_q, op_q, np_q;
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic          last_col_q, last_row_q, dir_q;

  logic [WW-1:0] fw, w_eff;
  logic [HW-1:0] fh, h_eff;
  logic          last_col, last_row, accept;
  pix_t          cur, lo, ln;
  logic          has_res, leave;

  assign fw    = WW'(cfg_i.frame_width);
  assign fh    = HW'(cfg_i.frame_height);
  assign w_eff = (fw < WW'(MIN_DIM)) ? WW'(MIN_DIM) :
                 (fw > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : fw;
  assign h_eff = (fh < HW'(MIN_DIM)) ? HW'(MIN_DIM) :
                 (fh > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : fh;

  assign last_col = WW'(col_cnt_q) >= (w_eff - WW'(1));
  assign last_row = HW'(row_cnt_q) >= (h_eff - HW'(1));

  assign cur         = {pix_i.in_blue, pix_i.in_green, pix_i.in_red};
  assign pix_i.ready = (state_q == F_IDLE);
  assign accept      = pix_i.valid && pix_i.ready;

  rgbsf_ram #(.WIDTH($bits(pix_t)), .DEPTH(MAX_WIDTH)) u_older_line (
    .clk_i     (clk_i),
    .wr_en_i   (leave),
    .wr_addr_i (col_q),
    .wr_data_i (ln),
    .rd_en_i   (accept),
    .rd_addr_i (col_cnt_q),
    .rd_data_o (lo)
  );

  rgbsf_ram #(.WIDTH($bits(pix_t)), .DEPTH(MAX_WIDTH)) u_newer_line (
    .clk_i     (clk_i),
    .wr_en_i   (leave),
    .wr_addr_i (col_q),
    .wr_data_i (cur_q),
    .rd_en_i   (accept),
    .rd_addr_i (col_cnt_q),
    .rd_data_o (ln)
  );

  assign has_res = dir_q ? (row_q >= RW'(2)) : (col_q >= CW'(2));
  assign leave   = (state_q == F_LOOK) && (!has_res || !full_i);
  assign push_o  = (state_q == F_LOOK) && has_res && !full_i;

  always_comb begin
    job_o.p0    = dir_q ? lo : op_q;
    job_o.p1    = dir_q ? ln : np_q;
    job_o.p2    = cur_q;
    job_o.dir   = dir_q;
    job_o.three = dir_q ? last_row_q : last_col_q;
  end

  assign col_o = col_q;
  assign row_o = row_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:  if (accept) state_d = F_LOOK;
      F_LOOK:  if (leave) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      older_pix_q <= '0;
      newer_pix_q <= '0;
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        older_pix_q <= newer_pix_q;
        newer_pix_q <= cur;
        if (last_col) begin
          col_cnt_q <= '0;
          row_cnt_q <= last_row ? '0 : row_cnt_q + RW'(1);
        end else begin
          col_cnt_q <= col_cnt_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q      <= cur;
      op_q       <= older_pix_q;
      np_q       <= newer_pix_q;
      col_q      <= col_cnt_q;
      row_q      <= row_cnt_q;
      last_col_q <= last_col;
      last_row_q <= last_row;
      dir_q      <= cfg_i.direction;
    end
  end

endmodule

/* rtl/rgbsf_fifo.sv */
// short job queue between front and back end
module rgbsf_fifo #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]    count_q;

  assign full_o  = (count_q == NW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + NW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/rgbsf_back.sv */
// back end: weighted sum, radix-2 division and result sequencing
module rgbsf_back import rgbsf_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [STR_W-1:0]              strength_i,
  input  logic                          empty_i,
  input  job_t                          job_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  col_i,
  input  logic [$clog2(MAX_HEIGHT)-1:0] row_i,
  output logic                          pop_o,
  rgbsf_res_if.source                   res_o
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned NUM_W = 2 * CH_W;
  localparam int unsigned REM_W = CH_W + 2;
  localparam int unsigned DIV_W = STR_W + 1;
  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_OUT  = 3'b100
  } bstate_e;

  bstate_e state_q, state_d;

  job_t                          job_q;
  logic [CW-1:0]                 col_q;
  logic [RW-1:0]                 row_q;
  logic [DIV_W-1:0]              div_q;
  logic [NUM_CH-1:0][REM_W-1:0]  rem_q;
  logic [NUM_CH-1:0][CH_W-1:0]   low_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [1:0]                    sel_q;

  logic [NUM_CH-1:0][NUM_W-1:0]  num;
  logic [NUM_CH-1:0][REM_W-1:0]  rem_d;
  logic [NUM_CH-1:0][CH_W-1:0]   low_d;
  logic                          out_done;
  pix_t                          out_pix;
  logic [CW-1:0]                 out_c;
  logic [RW-1:0]                 out_r;
  logic                          out_last;

  assign pop_o = (state_q == B_IDLE) && !empty_i;

  always_comb begin
    logic [REM_W-1:0] trial;
    logic [NUM_W-1:0] prod;
    num   = '0;
    rem_d = rem_q;
    low_d = low_q;
    for (int k = 0; k < NUM_CH; k++) begin
      prod   = NUM_W'(strength_i) * NUM_W'(job_i.p0[k]);
      num[k] = prod + NUM_W'(job_i.p1[k]) + NUM_W'(job_i.p2[k]);
      trial  = {rem_q[k][REM_W-2:0], low_q[k][CH_W-1]};
      if (trial >= REM_W'(div_q)) begin
        rem_d[k] = trial - REM_W'(div_q);
        low_d[k] = {low_q[k][CH_W-2:0], 1'b1};
      end else begin
        rem_d[k] = trial;
        low_d[k] = {low_q[k][CH_W-2:0], 1'b0};
      end
    end
  end

  // result order: filtered, then, for the last pixel of a run only, the two passthrough pixels
  always_comb begin
    out_pix  = low_q;
    out_c    = col_q;
    out_r    = row_q;
    out_last = !job_q.three;
    case (sel_q)
      2'd0: begin
        out_pix = low_q;
        if (job_q.dir) out_r = row_q - RW'(2);
        else           out_c = col_q - CW'(2);
        out_last = !job_q.three;
      end
      2'd1: begin
        out_pix = job_q.p1;
        if (job_q.dir) out_r = row_q - RW'(1);
        else           out_c = col_q - CW'(1);
        out_last = 1'b0;
      end
      2'd2: begin
        out_pix  = job_q.p2;
        out_last = 1'b1;
      end
      default: begin
        out_pix  = job_q.p2;
        out_last = 1'b1;
      end
    endcase
  end

  assign res_o.valid       = (state_q == B_OUT);
  assign res_o.out_red     = out_pix[0];
  assign res_o.out_green   = out_pix[1];
  assign res_o.out_blue    = out_pix[2];
  assign res_o.out_col     = COL_W'(out_c);
  assign res_o.out_row     = ROW_W'(out_r);
  assign res_o.last_of_run = out_last;

  assign out_done = res_o.valid && res_o.ready && out_last;

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (pop_o) state_d = B_DIV;
      B_DIV:   if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = B_OUT;
      B_OUT:   if (out_done) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      cnt_q   <= '0;
      sel_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        B_IDLE: begin
          cnt_q <= '0;
          sel_q <= '0;
        end
        B_DIV: cnt_q <= cnt_q + CNT_W'(1);
        B_OUT: begin
          if (res_o.valid && res_o.ready) begin
            sel_q <= sel_q + 2'd1;
          end
        end
        default: begin
          cnt_q <= '0;
          sel_q <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
      col_q <= col_i;
      row_q <= row_i;
      div_q <= DIV_W'(strength_i) + DIV_W'(2);
      for (int k = 0; k < NUM_CH; k++) begin
        rem_q[k] <= REM_W'(num[k][NUM_W-1:CH_W]);
        low_q[k] <= num[k][CH_W-1:0];
      end
    end else if (state_q == B_DIV) begin
      rem_q <= rem_d;
      low_q <= low_d;
    end
  end

endmodule

/* rtl/rgb_three_tap_smoothing_filter_unit.sv */
// top level of the rgb three-tap smoothing filter
//
//   channel  dir  payload                                         moves
//   pix_i    in   in_red, in_green, in_blue                       one pixel request
//   res_o    out  out_red/green/blue, out_col, out_row, last_of_run  one result request
//   cfg_i    in   index, data                                     one register write
//
// front end reads the line stores for a pixel, then writes them back, before it takes
// the next pixel, and it stalls while the job queue is full; each job is loaded, runs
// 8 divider steps and gives 1 or 3 results, and no new job is popped before its last
// result is taken; a 2-deep job queue lets front and back stall independently; no clearing pass
// async active-low reset clears position counters, pixel taps and state, and sets config registers to defaults
module rgb_three_tap_smoothing_filter_unit import rgbsf_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rgbsf_pix_if.sink   pix_i,
  rgbsf_res_if.source res_o,
  rgbsf_cfg_if.sink   cfg_i
);

  localparam int unsigned CW     = $clog2(MAX_WIDTH);
  localparam int unsigned RW     = $clog2(MAX_HEIGHT);
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QW     = $bits(job_t) + CW + RW;

  cfg_t          cfg_q;
  logic          push, full, pop, empty;
  job_t          job_in, job_out;
  logic [CW-1:0] col_in, col_out;
  logic [RW-1:0] row_in, row_out;
  logic [QW-1:0] q_out;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.strength     <= STRENGTH_RST;
      cfg_q.frame_width  <= WIDTH_RST;
      cfg_q.frame_height <= HEIGHT_RST;
      cfg_q.direction    <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_STRENGTH:  cfg_q.strength     <= cfg_i.data[STR_W-1:0];
        CFG_WIDTH:     cfg_q.frame_width  <= cfg_i.data[DIM_W-1:0];
        CFG_HEIGHT:    cfg_q.frame_height <= cfg_i.data[DIM_W-1:0];
        CFG_DIRECTION: cfg_q.direction    <= cfg_i.data[0];
        default:       ;
      endcase
    end
  end

  rgbsf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .pix_i  (pix_i),
    .push_o (push),
    .job_o  (job_in),
    .col_o  (col_in),
    .row_o  (row_in),
    .full_i (full)
  );

  rgbsf_fifo #(.WIDTH(QW), .DEPTH(QDEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({job_in, col_in, row_in}),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (q_out),
    .empty_o (empty)
  );

  assign {job_out, col_out, row_out} = q_out;

  rgbsf_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .strength_i (cfg_q.strength),
    .empty_i    (empty),
    .job_i      (job_out),
    .col_i      (col_out),
    .row_i      (row_out),
    .pop_o      (pop),
    .res_o      (res_o)
  );

endmodule
